[design/lir_pkg.sv]
// ----------------------------------------------------------------------------
// lir_pkg: shared types and constants of the linear interpolation resampler
// Field widths, output rate constants, divider reciprocal and register codes.
// ----------------------------------------------------------------------------
package lir_pkg;

	// field widths
	localparam int unsigned SAMPLE_W = 16;
	localparam int unsigned FRAMES_W = 24;
	localparam int unsigned RATE_W   = 18;
	localparam int unsigned PHASE_W  = 18;
	localparam int unsigned LIM_W    = 20;
	localparam int unsigned DIFF_W   = SAMPLE_W + 1;
	localparam int unsigned QUO_W    = 19;

	// rates
	localparam int unsigned OUT_HZ      = 48000;
	localparam int unsigned HALF_OUT_HZ = OUT_HZ / 2;
	localparam int unsigned RATE_MIN    = 8000;
	localparam int unsigned RATE_MAX    = 192000;

	// floor(u / 48000) = floor((u >> 7) * M >> 35), exact for u below 2^33
	localparam int unsigned PRE_SHIFT   = 7;
	localparam int unsigned RECIP_SHIFT = 35;
	localparam logic [26:0] RECIP_M     = 27'd91625969;
	localparam int unsigned QUOT_W      = 18;

	// keeps the numerator nonnegative: 65536 * 48000 plus the rounding half
	localparam logic [33:0] DIV_BIAS = 34'(64'd65536 * 64'(OUT_HZ) + 64'(HALF_OUT_HZ));
	localparam logic [QUO_W-1:0] QUOT_OFFSET = 19'd65536;

	// configuration register indexes
	localparam logic CFG_INPUT_RATE   = 1'b0;
	localparam logic CFG_CHANNEL_MODE = 1'b1;

	// channel mode codes
	localparam logic [1:0] MODE_MONO   = 2'd1;
	localparam logic [1:0] MODE_STEREO = 2'd2;

	// control of the shared multiply unit
	typedef struct packed {
		logic en;     // load the product register
		logic recip;  // 1: reciprocal step on the held product, 0: diff * phase
	} mul_ctl_t;

endpackage

[design/linear_interpolation_resampler_core.sv]
// ----------------------------------------------------------------------------
// linear_interpolation_resampler_core: clip resampler to 48000 Hz
// Linear interpolation between neighboring frames at an exact rational
// phase, rounded half up; the last frame of a clip also emits the tail.
// ----------------------------------------------------------------------------
//
//  channel  | direction | beat contents
//  ---------+-----------+------------------------------------------------------
//  s_axis   | in        | tdata: left_sample, right_sample, clip_frames
//  m_axis   | out       | tdata: out_left, out_right; tlast: run_last;
//           |           | tuser: clip_end
//  cfg      | in        | write only: 0 input_rate, 1 channel_mode
//
//  steps: an input frame is accepted, started and finished; each
//  interpolated output adds a loop check, the left and right multiply and
//  reciprocal steps and the emit step, each tail output a loop check and the
//  emit step, and a loop check that ends without an output (phase wrap or
//  clip end) adds only itself; the single shared multiplier takes four products per interpolated output
//  s_axis_tready is high only while the sequencer idles
//  a full output register stalls the sequencer in its emit step
//  reset: asynchronous, clears the clip state; no memory clearing pass
//
module linear_interpolation_resampler_core (
	input  logic        clk,
	input  logic        arst_n,
	// input frames
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [55:0] s_axis_tdata,   // [15:0] left_sample, [31:16] right_sample,
	                                    // [55:32] clip_frames
	// output frames
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [15:0] out_left, [31:16] out_right
	output logic        m_axis_tlast,   // run_last
	output logic [0:0]  m_axis_tuser,   // [0] clip_end
	// configuration
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [17:0] cfg_data
);

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_START = 9'b000000010,
		ST_CHK   = 9'b000000100,
		ST_ML1   = 9'b000001000,
		ST_ML2   = 9'b000010000,
		ST_MR1   = 9'b000100000,
		ST_MR2   = 9'b001000000,
		ST_EMIT  = 9'b010000000,
		ST_FIN   = 9'b100000000
	} state_t;

	localparam int unsigned SW = lir_pkg::SAMPLE_W;

	state_t state_q;

	// configuration registers
	logic [lir_pkg::RATE_W-1:0]   input_rate_q;
	logic [1:0]                   channel_mode_q;

	// clip state carried between input frames
	logic signed [SW-1:0]         prev_l_q;
	logic signed [SW-1:0]         prev_r_q;
	logic [lir_pkg::FRAMES_W-1:0] frame_index_q;
	logic [lir_pkg::PHASE_W-1:0]  phase_q;     // also the loop phase while working
	logic                         done_q;      // no further output of this clip

	// current frame and loop context
	logic signed [SW-1:0]         cur_l_q;
	logic signed [SW-1:0]         cur_r_q;
	logic [lir_pkg::FRAMES_W-1:0] frames_q;
	logic [lir_pkg::RATE_W-1:0]   rate_q;
	logic                         last_q;      // this frame ends the clip
	logic                         ph2_q;       // tail part: right neighbor clamped
	logic [lir_pkg::LIM_W-1:0]    lim_q;       // clip end relative to the left frame
	logic signed [SW-1:0]         res_l_q;

	// output register
	logic                         out_valid_q;
	logic [SW-1:0]                out_l_q;
	logic [SW-1:0]                out_r_q;
	logic                         out_last_q;
	logic                         out_end_q;

	// input beat fields
	logic signed [SW-1:0]         in_l;
	logic signed [SW-1:0]         in_r;
	logic [lir_pkg::FRAMES_W-1:0] in_frames;
	logic [lir_pkg::RATE_W-1:0]   rate_sat;
	logic                         in_take;

	// loop arithmetic
	logic [lir_pkg::LIM_W-1:0]    sum1;        // phase + rate
	logic [lir_pkg::LIM_W-1:0]    sum2;        // phase + 2 * rate
	logic                         wrap;
	logic                         fits;
	logic                         clip_end_c;
	logic                         run_last_c;
	logic                         out_take;

	// start step
	logic                         last_c;
	logic [lir_pkg::FRAMES_W-1:0] diff_c;
	logic [3:0]                   span_c;
	logic [lir_pkg::LIM_W-1:0]    lim_start;

	// shared unit
	lir_pkg::mul_ctl_t              mul_ctl;
	logic signed [lir_pkg::DIFF_W-1:0] mul_diff;
	logic signed [lir_pkg::DIFF_W-1:0] diff_l;
	logic signed [lir_pkg::DIFF_W-1:0] diff_r;
	logic signed [lir_pkg::QUO_W-1:0]  quo;
	logic signed [lir_pkg::QUO_W-1:0]  sum_l;
	logic signed [lir_pkg::QUO_W-1:0]  sum_r;

	assign in_l      = s_axis_tdata[15:0];
	assign in_r      = s_axis_tdata[31:16];
	assign in_frames = s_axis_tdata[55:32];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_take       = s_axis_tvalid && s_axis_tready;

	// rate out of range is clamped
	always_comb begin
		if (input_rate_q < lir_pkg::RATE_W'(lir_pkg::RATE_MIN)) begin
			rate_sat = lir_pkg::RATE_W'(lir_pkg::RATE_MIN);
		end else if (input_rate_q > lir_pkg::RATE_W'(lir_pkg::RATE_MAX)) begin
			rate_sat = lir_pkg::RATE_W'(lir_pkg::RATE_MAX);
		end else begin
			rate_sat = input_rate_q;
		end
	end

	// frame is last when the clip length is not past frame_index + 1
	assign last_c = ({1'b0, frames_q} <= ({1'b0, frame_index_q} + 25'd1));
	assign diff_c = frames_q - frame_index_q;

	// frames from the left neighbor to the clip end, saturated far beyond reach
	always_comb begin
		if (last_c) begin
			span_c = 4'd2;
		end else if (diff_c >= 24'd14) begin
			span_c = 4'd15;
		end else begin
			span_c = diff_c[3:0] + 4'd1;
		end
	end

	assign lim_start = lir_pkg::LIM_W'(span_c) * lir_pkg::LIM_W'(lir_pkg::OUT_HZ);

	// output position tests against the clip end
	assign sum1       = lir_pkg::LIM_W'(phase_q) + lir_pkg::LIM_W'(rate_q);
	assign sum2       = sum1 + lir_pkg::LIM_W'(rate_q);
	assign wrap       = (phase_q >= lir_pkg::PHASE_W'(lir_pkg::OUT_HZ));
	assign fits       = (sum1 <= lim_q);
	assign clip_end_c = (sum2 > lim_q);
	// the interval closes with this output unless the tail follows
	assign run_last_c = clip_end_c
		|| (!ph2_q && !last_q && (sum1 >= lir_pkg::LIM_W'(lir_pkg::OUT_HZ)));

	assign out_take = !out_valid_q || m_axis_tready;

	// neighbor differences
	assign diff_l = {cur_l_q[SW-1], cur_l_q} - {prev_l_q[SW-1], prev_l_q};
	assign diff_r = {cur_r_q[SW-1], cur_r_q} - {prev_r_q[SW-1], prev_r_q};

	// interpolated value: left neighbor plus rounded share of the difference
	assign sum_l = {{(lir_pkg::QUO_W - SW){prev_l_q[SW-1]}}, prev_l_q} + quo;
	assign sum_r = {{(lir_pkg::QUO_W - SW){prev_r_q[SW-1]}}, prev_r_q} + quo;

	// sequencer drives the shared unit
	always_comb begin
		mul_ctl  = '0;
		mul_diff = diff_l;
		unique case (state_q)
			ST_ML1: begin
				mul_ctl.en = 1'b1;
			end
			ST_ML2, ST_MR2: begin
				mul_ctl.en    = 1'b1;
				mul_ctl.recip = 1'b1;
			end
			ST_MR1: begin
				mul_ctl.en = 1'b1;
				mul_diff   = diff_r;
			end
			default: begin
				mul_ctl = '0;
			end
		endcase
	end

	lir_interp_unit u_interp (
		.clk   (clk),
		.ctl   (mul_ctl),
		.diff  (mul_diff),
		.phase (phase_q[15:0]),
		.quo   (quo)
	);

	// control and clip state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			out_valid_q    <= 1'b0;
			input_rate_q   <= lir_pkg::RATE_W'(lir_pkg::OUT_HZ);
			channel_mode_q <= lir_pkg::MODE_STEREO;
			prev_l_q       <= '0;
			prev_r_q       <= '0;
			frame_index_q  <= '0;
			phase_q        <= '0;
			done_q         <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					lir_pkg::CFG_INPUT_RATE:   input_rate_q   <= cfg_data;
					lir_pkg::CFG_CHANNEL_MODE: channel_mode_q <= cfg_data[1:0];
					default:                   input_rate_q   <= input_rate_q;
				endcase
			end

			// beat taken downstream; the emit step sets the flag on its own
			if (m_axis_tready && (state_q != ST_EMIT)) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						state_q <= ST_START;
					end
				end
				ST_START: begin
					if ((frame_index_q != '0) && !done_q) begin
						state_q <= ST_CHK;
					end else if (last_c && !done_q) begin
						state_q <= ST_CHK;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_CHK: begin
					if (ph2_q) begin
						state_q <= fits ? ST_EMIT : ST_FIN;
					end else if (wrap) begin
						// interval done, phase moves on to the next left frame
						phase_q <= phase_q - lir_pkg::PHASE_W'(lir_pkg::OUT_HZ);
						if (!last_q) begin
							state_q <= ST_FIN;
						end
					end else if (!fits) begin
						done_q  <= 1'b1;
						state_q <= ST_FIN;
					end else begin
						state_q <= ST_ML1;
					end
				end
				ST_ML1: state_q <= ST_ML2;
				ST_ML2: state_q <= ST_MR1;
				ST_MR1: state_q <= ST_MR2;
				ST_MR2: state_q <= ST_EMIT;
				ST_EMIT: begin
					if (out_take) begin
						out_valid_q <= 1'b1;
						phase_q     <= sum1[lir_pkg::PHASE_W-1:0];
						state_q     <= ST_CHK;
					end
				end
				ST_FIN: begin
					if (last_q) begin
						// clip over: next beat starts a new clip
						prev_l_q      <= '0;
						prev_r_q      <= '0;
						frame_index_q <= '0;
						phase_q       <= '0;
						done_q        <= 1'b0;
					end else begin
						prev_l_q      <= cur_l_q;
						prev_r_q      <= cur_r_q;
						frame_index_q <= frame_index_q + 24'd1;
					end
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// frame and loop context, output payload
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_take) begin
					cur_l_q  <= in_l;
					// mono copies left into right
					cur_r_q  <= (channel_mode_q == lir_pkg::MODE_MONO) ? in_l : in_r;
					frames_q <= (in_frames == '0) ? 24'd1 : in_frames;
					rate_q   <= rate_sat;
				end
			end
			ST_START: begin
				last_q <= last_c;
				if (frame_index_q != '0) begin
					ph2_q <= 1'b0;
					lim_q <= lim_start;
				end else begin
					// first frame of a one-frame clip: tail only
					ph2_q <= 1'b1;
					lim_q <= lir_pkg::LIM_W'(lir_pkg::OUT_HZ);
				end
			end
			ST_CHK: begin
				if (!ph2_q && wrap && last_q) begin
					ph2_q <= 1'b1;
					lim_q <= lim_q - lir_pkg::LIM_W'(lir_pkg::OUT_HZ);
				end
			end
			ST_MR1: begin
				res_l_q <= sum_l[SW-1:0];
			end
			ST_EMIT: begin
				if (out_take) begin
					if (ph2_q) begin
						out_l_q <= cur_l_q;
						out_r_q <= cur_r_q;
					end else begin
						out_l_q <= res_l_q;
						out_r_q <= sum_r[SW-1:0];
					end
					out_last_q <= run_last_c;
					out_end_q  <= clip_end_c;
				end
			end
			default: begin
				res_l_q <= res_l_q;
			end
		endcase
	end

	assign m_axis_tvalid   = out_valid_q;
	assign m_axis_tdata    = {out_r_q, out_l_q};
	assign m_axis_tlast    = out_last_q;
	assign m_axis_tuser[0] = out_end_q;

	// interpolation only runs with the phase inside the interval
	a_phase_in_interval: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ML1) |-> (phase_q < lir_pkg::PHASE_W'(lir_pkg::OUT_HZ)))
		else $error("interpolation started with phase past the interval");

	// the final frame of a clip always closes the run of its input frame
	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[0]) |-> m_axis_tlast)
		else $error("clip end without run end");

	// nothing is emitted once the clip is exhausted
	a_no_emit_when_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> !done_q)
		else $error("output after clip end");

endmodule

[design/lir_interp_unit.sv]
// ----------------------------------------------------------------------------
// lir_interp_unit: shared multiplier of the interpolator
// One registered 28x28 multiplier: first diff * phase, then the constant
// division by 48000 of the rounded numerator via a reciprocal multiply.
// ----------------------------------------------------------------------------
module lir_interp_unit (
	input  logic                                 clk,
	input  lir_pkg::mul_ctl_t                    ctl,
	input  logic signed [lir_pkg::DIFF_W-1:0]    diff,
	input  logic        [15:0]                   phase,
	output logic signed [lir_pkg::QUO_W-1:0]     quo
);

	logic signed [55:0] prod_q;
	logic        [33:0] num;
	logic        [25:0] pre;
	logic signed [27:0] op_a;
	logic signed [27:0] op_b;

	// numerator of the held diff * phase product, biased to stay positive
	assign num = prod_q[33:0] + lir_pkg::DIV_BIAS;
	assign pre = num[lir_pkg::PRE_SHIFT +: 26];

	always_comb begin
		if (ctl.recip) begin
			op_a = $signed({2'b00, pre});
			op_b = $signed({1'b0, lir_pkg::RECIP_M});
		end else begin
			op_a = $signed({{(28 - lir_pkg::DIFF_W){diff[lir_pkg::DIFF_W-1]}}, diff});
			op_b = $signed({12'd0, phase});
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			prod_q <= op_a * op_b;
		end
	end

	// quotient minus the bias term, valid after a reciprocal step
	assign quo = $signed({1'b0, prod_q[lir_pkg::RECIP_SHIFT +: lir_pkg::QUOT_W]})
		- $signed(lir_pkg::QUOT_OFFSET);

endmodule
